[rtl/sfkst_pkg.sv]
// Package: shared constants, opcodes and word types for the scancode queue and key state tracker.
package sfkst_pkg;

    localparam int QUEUE_DEPTH = 256;
    localparam int PTR_SPAN    = 2 * QUEUE_DEPTH;
    localparam int PTR_W       = $clog2(PTR_SPAN);
    localparam int SLOT_W      = $clog2(QUEUE_DEPTH);
    localparam int KEY_COUNT   = 128;
    localparam int KEY_W       = $clog2(KEY_COUNT);
    localparam int CODE_W      = 8;
    localparam int COUNT_W     = 9;
    localparam int OP_W        = 2;
    localparam int RELEASE_BIT = 7;

    localparam logic [OP_W-1:0] OP_PUSH  = 2'd0;
    localparam logic [OP_W-1:0] OP_APPLY = 2'd1;
    localparam logic [OP_W-1:0] OP_CLEAR = 2'd2;
    localparam logic [OP_W-1:0] OP_QUERY = 2'd3;

    typedef struct packed {
        logic [OP_W-1:0]   operation;
        logic [CODE_W-1:0] scancode;
        logic [KEY_W-1:0]  key_index;
    } t_in_word;

    typedef struct packed {
        logic               push_accepted;
        logic               popped_valid;
        logic [CODE_W-1:0]  popped_scancode;
        logic [COUNT_W-1:0] fill_count;
        logic               key_is_down;
        logic               key_was_pressed;
        logic               key_was_released;
    } t_out_word;

endpackage

[rtl/scancode_fifo_key_state_tracker.sv]
// Top level: scancode ring queue with per-key down, pressed and released marks.
// Throughput: one word per cycle when the output side does not stall.
// The queue read is registered in stage one and the result in the output register of stage two.
// Stage one updates the pointers and writes or reads the queue, stage two applies the mark update.
// Reset (synchronous, active low) empties the queue and clears all marks; queue contents are kept.
module scancode_fifo_key_state_tracker
    import sfkst_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    input  t_in_word  i_in_word,
    output logic      o_in_stall,
    output logic      o_out_valid,
    output t_out_word o_out_word,
    input  logic      i_out_stall
);

    logic [CODE_W-1:0] r_queue_mem [QUEUE_DEPTH];
    logic [CODE_W-1:0] r_rd_data;

    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;

    logic [KEY_COUNT-1:0] r_down, n_down;
    logic [KEY_COUNT-1:0] r_pressed, n_pressed;
    logic [KEY_COUNT-1:0] r_released, n_released;

    logic               r_a_valid;
    logic [OP_W-1:0]    r_a_op;
    logic [KEY_W-1:0]   r_a_key;
    logic               r_a_push_ok;
    logic               r_a_pop_ok;
    logic [PTR_W-1:0]   r_a_count;

    logic      r_o_valid;
    t_out_word r_o_word, n_o_word;

    logic             accept;
    logic             advance;
    logic [PTR_W-1:0] fill;
    logic [PTR_W-1:0] n_fill;
    logic [SLOT_W-1:0] wr_slot, rd_slot;
    logic             full, empty;
    logic             push_ok, pop_ok;
    logic [KEY_W-1:0] ev_key;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        logic [PTR_W:0] s;
        s = {1'b0, p} + 1'b1;
        if (s == (PTR_W+1)'(PTR_SPAN)) begin
            return '0;
        end
        return s[PTR_W-1:0];
    endfunction

    function automatic logic [SLOT_W-1:0] ptr_slot(input logic [PTR_W-1:0] p);
        if ({1'b0, p} >= (PTR_W+1)'(QUEUE_DEPTH)) begin
            return SLOT_W'({1'b0, p} - (PTR_W+1)'(QUEUE_DEPTH));
        end
        return SLOT_W'(p);
    endfunction

    function automatic logic [PTR_W-1:0] ptr_diff(input logic [PTR_W-1:0] w,
                                                  input logic [PTR_W-1:0] r);
        if (w >= r) begin
            return w - r;
        end
        return PTR_W'(({1'b0, w} + (PTR_W+1)'(PTR_SPAN)) - {1'b0, r});
    endfunction

    // pipeline control
    assign advance    = r_a_valid && (!r_o_valid || !i_out_stall);
    assign o_in_stall = r_a_valid && !advance;
    assign accept     = i_in_valid && !o_in_stall;

    // stage one: pointers and queue access
    assign fill    = ptr_diff(r_wr_ptr, r_rd_ptr);
    assign full    = (fill == PTR_W'(QUEUE_DEPTH));
    assign empty   = (fill == '0);
    assign wr_slot = ptr_slot(r_wr_ptr);
    assign rd_slot = ptr_slot(r_rd_ptr);
    assign push_ok = accept && (i_in_word.operation == OP_PUSH) && !full;
    assign pop_ok  = accept && (i_in_word.operation == OP_APPLY) && !empty;
    assign n_wr_ptr = push_ok ? ptr_inc(r_wr_ptr) : r_wr_ptr;
    assign n_rd_ptr = pop_ok ? ptr_inc(r_rd_ptr) : r_rd_ptr;
    assign n_fill   = ptr_diff(n_wr_ptr, n_rd_ptr);

    always_ff @(posedge i_clk) begin
        if (push_ok) begin
            r_queue_mem[wr_slot] <= i_in_word.scancode;
        end
        if (pop_ok) begin
            r_rd_data <= r_queue_mem[rd_slot];
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_a_op      <= i_in_word.operation;
            r_a_key     <= i_in_word.key_index;
            r_a_push_ok <= push_ok;
            r_a_pop_ok  <= pop_ok;
            r_a_count   <= n_fill;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_ptr  <= '0;
            r_wr_ptr  <= '0;
            r_a_valid <= 1'b0;
        end else begin
            r_rd_ptr  <= n_rd_ptr;
            r_wr_ptr  <= n_wr_ptr;
            r_a_valid <= accept || o_in_stall;
        end
    end

    // stage two: mark update and result
    assign ev_key = r_rd_data[KEY_W-1:0];

    always_comb begin
        n_down     = r_down;
        n_pressed  = r_pressed;
        n_released = r_released;
        if (advance) begin
            case (r_a_op)
                OP_APPLY: begin
                    if (r_a_pop_ok) begin
                        if (r_rd_data[RELEASE_BIT]) begin
                            n_released[ev_key] = 1'b1;
                            n_down[ev_key]     = 1'b0;
                        end else begin
                            n_pressed[ev_key] = 1'b1;
                            n_down[ev_key]    = 1'b1;
                        end
                    end
                end
                OP_CLEAR: begin
                    n_pressed  = '0;
                    n_released = '0;
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        n_o_word.push_accepted    = r_a_push_ok;
        n_o_word.popped_valid     = r_a_pop_ok;
        n_o_word.popped_scancode  = r_a_pop_ok ? r_rd_data : '0;
        n_o_word.fill_count       = COUNT_W'(r_a_count);
        n_o_word.key_is_down      = n_down[r_a_key];
        n_o_word.key_was_pressed  = n_pressed[r_a_key];
        n_o_word.key_was_released = n_released[r_a_key];
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_o_word <= n_o_word;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_down     <= '0;
            r_pressed  <= '0;
            r_released <= '0;
            r_o_valid  <= 1'b0;
        end else begin
            r_down     <= n_down;
            r_pressed  <= n_pressed;
            r_released <= n_released;
            r_o_valid  <= advance || (r_o_valid && i_out_stall);
        end
    end

    assign o_out_valid = r_o_valid;
    assign o_out_word  = r_o_word;

endmodule
